// File: rtl/square_wave_channel_with_sweep_defines.svh
// ----------------------------------------------------------------------------
// Pulse channel assertion macros
// Concurrent check helpers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAVE_CHANNEL_WITH_SWEEP_DEFINES_SVH
`define SQUARE_WAVE_CHANNEL_WITH_SWEEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled during reset.
`define SWC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pulse channel check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define SWC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pulse channel check failed");
`else
`define SWC_ASSERT_IMP(label, ante, cons)
`define SWC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// Pulse channel package
// Operation codes, register indexes, state encoding and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W     = 5;

	typedef enum logic [2:0] {
		OP_TICK         = 3'd0,
		OP_QUARTER      = 3'd1,
		OP_HALF         = 3'd2,
		OP_LOAD_TIMER   = 3'd3,
		OP_LOAD_LENGTH  = 3'd4,
		OP_RESTART      = 3'd5,
		OP_SWEEP_RELOAD = 3'd6
	} swc_op_t;

	typedef enum logic [2:0] {
		REG_DUTY      = 3'd0,
		REG_ENABLE    = 3'd1,
		REG_HALT      = 3'd2,
		REG_ENVELOPE  = 3'd3,
		REG_SWEEP     = 3'd4,
		REG_TIME_STEP = 3'd5
	} swc_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_CMP
	} swc_state_t;

	typedef struct packed {
		logic exec_op;
		logic tick_start;
		logic div_step;
		logic mul_step;
		logic out_load;
	} swc_cmd_t;

	typedef struct packed {
		logic out_free;
	} swc_sts_t;

endpackage

`default_nettype wire

// File: rtl/swc_in_if.sv
// ----------------------------------------------------------------------------
// Pulse channel input channel
// Valid/ready channel carrying one operation and its load value.
// ----------------------------------------------------------------------------
`default_nettype none

interface swc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [10:0] load_value;

	modport source (output valid, output operation, output load_value, input ready);
	modport sink (input valid, input operation, input load_value, output ready);
endinterface

`default_nettype wire

// File: rtl/swc_out_if.sv
// ----------------------------------------------------------------------------
// Pulse channel output channel
// Valid/ready channel carrying one sample level and the current timer.
// ----------------------------------------------------------------------------
`default_nettype none

interface swc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  sample_level;
	logic [11:0] timer_now;

	modport source (output valid, output sample_level, output timer_now, input ready);
	modport sink (input valid, input sample_level, input timer_now, output ready);
endinterface

`default_nettype wire

// File: rtl/swc_ctrl.sv
// ----------------------------------------------------------------------------
// Pulse channel controller
// Sequences event handling and the serial phase computation of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [2:0]      in_op,
	output logic                 in_ready,
	input  wire swc_pkg::swc_sts_t sts,
	output swc_pkg::swc_cmd_t    cmd
);

	swc_pkg::swc_state_t            state_q, state_d;
	logic [swc_pkg::CNT_W-1:0]      cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			swc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == swc_pkg::OP_TICK) begin
						cmd.tick_start = 1'b1;
						cnt_d          = '0;
						state_d        = swc_pkg::ST_DIV;
					end else begin
						cmd.exec_op = 1'b1;
					end
				end
			end
			swc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == swc_pkg::CNT_W'(swc_pkg::DIV_STEPS - 1)) begin
					state_d = swc_pkg::ST_MUL;
				end
			end
			swc_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				state_d      = swc_pkg::ST_CMP;
			end
			swc_pkg::ST_CMP: begin
				// Hold the finished result until the output register frees up.
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = swc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/swc_dp.sv
// ----------------------------------------------------------------------------
// Pulse channel datapath
// Channel state, configuration, serial remainder unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_dp #(
	parameter int unsigned MIN_TIMER    = 8,
	parameter int unsigned MAX_TIMER    = 2047,
	parameter int unsigned ENVELOPE_TOP = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [23:0]       cfg_data,
	input  wire logic [2:0]        in_op,
	input  wire logic [10:0]       in_load_value,
	input  wire swc_pkg::swc_cmd_t cmd,
	output swc_pkg::swc_sts_t      sts,
	swc_out_if.source              out_ch
);

	// Configuration.
	logic [8:0]  duty_q;
	logic        enable_q;
	logic        halt_q;
	logic [5:0]  env_ctl_q;
	logic [7:0]  sweep_ctl_q;
	logic [23:0] step_q;

	// Channel state.
	logic [47:0] elapsed_q;
	logic [11:0] timer_q;
	logic [2:0]  sweep_cnt_q;
	logic [3:0]  env_cnt_q;
	logic [3:0]  env_lvl_q;
	logic [7:0]  len_q;

	// Phase computation.
	logic [31:0] dvd_q;
	logic [12:0] rem_q;
	logic [15:0] frac_q;
	logic [31:0] n_q;
	logic [21:0] prod_q;

	// Output register.
	logic        out_valid_q;
	logic [3:0]  out_level_q;
	logic [11:0] out_timer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			enable_q    <= 1'b0;
			halt_q      <= 1'b0;
			env_ctl_q   <= 6'd31;
			sweep_ctl_q <= '0;
			step_q      <= 24'd166185;
		end else if (cfg_write) begin
			case (cfg_index)
				swc_pkg::REG_DUTY:      duty_q      <= cfg_data[8:0];
				swc_pkg::REG_ENABLE:    enable_q    <= cfg_data[0];
				swc_pkg::REG_HALT:      halt_q      <= cfg_data[0];
				swc_pkg::REG_ENVELOPE:  env_ctl_q   <= cfg_data[5:0];
				swc_pkg::REG_SWEEP:     sweep_ctl_q <= cfg_data[7:0];
				swc_pkg::REG_TIME_STEP: step_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sweep, envelope and length clocks as combinational next-state logic.
	logic [11:0] delta;
	logic [11:0] sw_timer_d;
	logic [2:0]  sw_cnt_d;
	logic [3:0]  env_cnt_d;
	logic [3:0]  env_lvl_d;
	logic [7:0]  len_d;

	always_comb begin
		delta      = timer_q >> sweep_ctl_q[2:0];
		sw_timer_d = timer_q;
		sw_cnt_d   = sweep_cnt_q;
		if (sweep_cnt_q != 3'd0) begin
			sw_cnt_d = sweep_cnt_q - 3'd1;
		end else begin
			sw_cnt_d = sweep_ctl_q[6:4];
			if (sweep_ctl_q[7]) begin
				if (sweep_ctl_q[3]) begin
					sw_timer_d = timer_q - delta;
				end else if (timer_q <= 12'(MAX_TIMER)) begin
					sw_timer_d = timer_q + delta;
				end
			end
		end

		env_cnt_d = env_cnt_q;
		env_lvl_d = env_lvl_q;
		if (env_cnt_q != 4'd0) begin
			env_cnt_d = env_cnt_q - 4'd1;
		end else begin
			env_cnt_d = env_ctl_q[3:0];
			if (env_lvl_q != 4'd0) begin
				env_lvl_d = env_lvl_q - 4'd1;
			end else if (env_ctl_q[5]) begin
				env_lvl_d = 4'(ENVELOPE_TOP);
			end
		end

		len_d = len_q;
		if (!halt_q && len_q != 8'd0) begin
			len_d = len_q - 8'd1;
		end
		if (!enable_q) begin
			len_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			timer_q     <= '0;
			sweep_cnt_q <= '0;
			env_cnt_q   <= '0;
			env_lvl_q   <= 4'(ENVELOPE_TOP);
			len_q       <= '0;
		end else if (cmd.tick_start) begin
			elapsed_q <= elapsed_q + {24'd0, step_q};
		end else if (cmd.exec_op) begin
			case (in_op)
				swc_pkg::OP_QUARTER: begin
					sweep_cnt_q <= sw_cnt_d;
					timer_q     <= sw_timer_d;
				end
				swc_pkg::OP_HALF: begin
					len_q       <= len_d;
					env_cnt_q   <= env_cnt_d;
					env_lvl_q   <= env_lvl_d;
					sweep_cnt_q <= sw_cnt_d;
					timer_q     <= sw_timer_d;
				end
				swc_pkg::OP_LOAD_TIMER: begin
					timer_q <= {1'b0, in_load_value};
				end
				swc_pkg::OP_LOAD_LENGTH: begin
					len_q <= (in_load_value > 11'd255) ? 8'd255 : in_load_value[7:0];
				end
				swc_pkg::OP_RESTART: begin
					elapsed_q <= '0;
					env_cnt_q <= env_ctl_q[3:0];
					env_lvl_q <= 4'(ENVELOPE_TOP);
				end
				swc_pkg::OP_SWEEP_RELOAD: begin
					sweep_cnt_q <= sweep_ctl_q[6:4];
				end
				default: begin
				end
			endcase
		end
	end

	// The period in Q16 is (timer + 2) << 16, so the remainder of the whole
	// time word is the integer part taken modulo (timer + 2), with the
	// fraction bits passed through unchanged.
	logic [12:0] divisor;
	logic [13:0] trial;
	logic [28:0] span;
	logic [31:0] span_w;
	logic [31:0] r8;
	logic [31:0] n_d;

	always_comb begin
		divisor = 13'(timer_q) + 13'd2;
		trial   = {rem_q, dvd_q[31]};
		span    = {divisor, 16'd0};
		span_w  = {3'd0, span};
		r8      = {rem_q, frac_q, 3'd0};
		// Phase shifted back by one eighth, scaled by 8 * span.
		if (r8 >= span_w) begin
			n_d = r8 - span_w;
		end else begin
			n_d = r8 + (span_w << 3) - span_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_start) begin
			dvd_q  <= elapsed_q[47:16];
			frac_q <= elapsed_q[15:0];
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= 13'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[12:0];
			end
		end
		if (cmd.mul_step) begin
			n_q    <= n_d;
			prod_q <= 22'(divisor) * 22'(duty_q);
		end
	end

	logic       wave_high;
	logic [3:0] level;

	always_comb begin
		wave_high = {1'b0, n_q, 5'd0} < {prod_q, 16'd0};
		level     = 4'd0;
		if (wave_high) begin
			level = env_ctl_q[4] ? env_ctl_q[3:0] : env_lvl_q;
		end
		if (timer_q < 12'(MIN_TIMER) || timer_q > 12'(MAX_TIMER)) begin
			level = 4'd0;
		end
		if (!enable_q || len_q == 8'd0) begin
			level = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_level_q <= level;
			out_timer_q <= timer_q;
		end
	end

	assign sts.out_free       = !out_valid_q || out_ch.ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_level = out_level_q;
	assign out_ch.timer_now    = out_timer_q;

endmodule

`default_nettype wire

// File: rtl/square_wave_channel_with_sweep.sv
// An event other than a sample tick takes effect in the cycle it is accepted.
// A sample tick passes the bit-serial remainder unit, the multiply step and the compare step,
// which waits while the output register is still full, before its beat is loaded there.
// Other events are taken one per cycle while idle; a tick closes the input until its beat is loaded.
// Reset (arst_n low, asynchronous) restores configuration, channel, controller and output valid state.
// ----------------------------------------------------------------------------
// Pulse channel with sweep
// Event-driven square-wave sound channel with envelope, length and sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_wave_channel_with_sweep_defines.svh"

module square_wave_channel_with_sweep #(
	parameter int unsigned MIN_TIMER    = 8,
	parameter int unsigned MAX_TIMER    = 2047,
	parameter int unsigned ENVELOPE_TOP = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	swc_in_if.sink           in_ch,
	swc_out_if.source        out_ch
);

	// The controller owns sequencing only. It accepts an event when idle,
	// runs a sample tick through the serial remainder, the multiply and the
	// compare, and waits in the compare step while the output register is
	// still full. Every non-tick event is applied by the datapath in the
	// accepting cycle, so the input stays open for the next beat.
	swc_pkg::swc_cmd_t cmd;
	swc_pkg::swc_sts_t sts;
	logic              in_rdy;

	swc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (in_rdy),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds configuration, the channel state, the remainder
	// unit (one quotient bit per cycle over the 32-bit integer part of the
	// time word) and the output register that separates the two channels.
	swc_dp #(
		.MIN_TIMER    (MIN_TIMER),
		.MAX_TIMER    (MAX_TIMER),
		.ENVELOPE_TOP (ENVELOPE_TOP)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_op         (in_ch.operation),
		.in_load_value (in_ch.load_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_ch        (out_ch)
	);

	assign in_ch.ready = in_rdy;

	// A sample tick closes the input until its beat has been loaded into the output register.
	`SWC_ASSERT_NXT(a_tick_blocks, in_ch.valid && in_ch.ready && in_ch.operation == swc_pkg::OP_TICK, !in_ch.ready)
	// Any other event leaves the input open in the following cycle.
	`SWC_ASSERT_NXT(a_event_open, in_ch.valid && in_ch.ready && in_ch.operation != swc_pkg::OP_TICK, in_ch.ready)
	// A result is only loaded when the output register can take it.
	`SWC_ASSERT_IMP(a_load_free, cmd.out_load, !out_ch.valid || out_ch.ready)
	// A loaded result is offered in the next cycle.
	`SWC_ASSERT_NXT(a_load_shows, cmd.out_load, out_ch.valid)

endmodule

`default_nettype wire

// File: verif/square_wave_channel_with_sweep_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse channel with sweep regression
// Drives operation beats into the channel, mirrors the channel's state in a
// behavioral predictor and compares every sample beat, field by field.
// ----------------------------------------------------------------------------

module square_wave_channel_with_sweep_test;

	localparam int unsigned MIN_TIMER    = 8;
	localparam int unsigned MAX_TIMER    = 2047;
	localparam int unsigned ENVELOPE_TOP = 15;

	// Operation code 7 has no meaning; the channel must swallow it silently.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// A sample beat reaches the output register once its tick has passed the remainder, multiply
	// and compare steps, so this many quiet cycles are enough to let any work finish.
	localparam int DRAIN_CYCLES    = 40;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int HOLD_CYCLES     = 300;
	// The limit leaves ample margin over the slowest correct run.
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic [3:0]  level;
		logic [11:0] timer;
	} beat_t;

	// One row of the directed sequence. Where typed is set, the expected beat
	// comes from the row itself rather than from the predictor.
	typedef struct packed {
		logic [2:0]  op;
		logic [10:0] value;
		logic        typed;
		logic [3:0]  level;
		logic [11:0] timer;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	swc_in_if  in_ch ();
	swc_out_if out_ch ();

	square_wave_channel_with_sweep #(
		.MIN_TIMER   (MIN_TIMER),
		.MAX_TIMER   (MAX_TIMER),
		.ENVELOPE_TOP(ENVELOPE_TOP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Mirror of the channel registers, updated whenever one is written.
	logic [8:0]  duty_cfg;
	logic        enable_cfg;
	logic        halt_cfg;
	logic [5:0]  envelope_cfg;
	logic [7:0]  sweep_cfg;
	logic [23:0] step_cfg;

	// Mirror of the channel state.
	logic [47:0] elapsed;
	logic [11:0] divider;
	logic [2:0]  sweep_count;
	logic [3:0]  envelope_count;
	logic [3:0]  envelope_level;
	logic [7:0]  length_count;

	// Sample beats that the channel still owes, oldest first.
	beat_t level_queue [$];

	int error_count;
	int items_sent;
	int beats_checked;
	int cycle_count;
	int sender_idle_pct;
	int receiver_idle_pct;
	bit hold_request;
	int hold_left;

	row_t directed_rows [0:24] = '{
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd0,  12'd0},
		'{OP_UNUSED,                11'd2047, 1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_LOAD_TIMER,   11'd2047, 1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd0,  12'd2047},
		'{swc_pkg::OP_LOAD_LENGTH,  11'd2047, 1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd15, 12'd2047},
		'{swc_pkg::OP_LOAD_TIMER,   11'd7,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd0,  12'd7},
		'{swc_pkg::OP_LOAD_TIMER,   11'd8,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd15, 12'd8},
		'{swc_pkg::OP_RESTART,      11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_HALF,         11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_QUARTER,      11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_SWEEP_RELOAD, 11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_LOAD_TIMER,   11'd1000, 1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_LOAD_LENGTH,  11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd0,  12'd1000},
		'{swc_pkg::OP_LOAD_LENGTH,  11'd1,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_HALF,         11'd0,    1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b1, 4'd0,  12'd1000},
		'{swc_pkg::OP_LOAD_LENGTH,  11'd200,  1'b0, 4'd0,  12'd0},
		'{swc_pkg::OP_TICK,         11'd0,    1'b0, 4'd0,  12'd0}
	};

	always #1 clk = ~clk;

	// The run is bounded by a plain cycle counter; running past it means the
	// channel stopped answering.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Level for the current tick. The phase is kept as an exact integer: with
	// span the Q16 length of one period, n is eight times the phase shifted
	// back by an eighth of a period, and the wave is high while n/(8*span)
	// stays below duty/256.
	function automatic logic [3:0] level_at_tick();
		logic [63:0] span;
		logic [63:0] rem;
		logic [63:0] full;
		logic [63:0] n;
		logic [3:0]  level;
		span = (64'(divider) + 64'd2) << 16;
		rem  = 64'(elapsed) % span;
		full = span << 3;
		n    = ((rem << 3) + full - span) % full;
		if ((n << 5) < span * 64'(duty_cfg))
			level = envelope_cfg[4] ? envelope_cfg[3:0] : envelope_level;
		else
			level = 4'd0;
		// Muted outside the usable timer range, when off, or when the length
		// counter has run out.
		if (divider < MIN_TIMER || divider > MAX_TIMER)
			level = 4'd0;
		if (!enable_cfg || length_count == 8'd0)
			level = 4'd0;
		return level;
	endfunction

	// The sweep divider reloads when it reaches zero, and only on that reload
	// does the timer move, by itself shifted right.
	task automatic clock_sweep_unit();
		logic [11:0] delta;
		if (sweep_count != 3'd0) begin
			sweep_count--;
		end else begin
			sweep_count = sweep_cfg[6:4];
			if (sweep_cfg[7]) begin
				delta = divider >> sweep_cfg[2:0];
				if (sweep_cfg[3])
					divider = divider - delta;
				else if (divider <= MAX_TIMER)
					divider = divider + delta;
			end
		end
	endtask

	task automatic clock_envelope_unit();
		if (envelope_count != 4'd0) begin
			envelope_count--;
		end else begin
			envelope_count = envelope_cfg[3:0];
			if (envelope_level != 4'd0)
				envelope_level--;
			else if (envelope_cfg[5])
				envelope_level = 4'(ENVELOPE_TOP);
		end
	endtask

	// Apply one accepted operation to the mirrored state; a sample tick also
	// yields the beat that the channel must produce for it.
	task automatic advance_channel(input logic [2:0] op, input logic [10:0] value,
			output beat_t beat, output bit produced);
		produced = 1'b0;
		beat     = '0;
		case (op)
		swc_pkg::OP_TICK: begin
			beat.level = level_at_tick();
			beat.timer = divider;
			produced   = 1'b1;
			elapsed    = elapsed + 48'(step_cfg);
		end
		swc_pkg::OP_QUARTER: begin
			clock_sweep_unit();
		end
		swc_pkg::OP_HALF: begin
			// Length first, then envelope, then sweep.
			if (!halt_cfg && length_count != 8'd0)
				length_count--;
			if (!enable_cfg)
				length_count = 8'd0;
			clock_envelope_unit();
			clock_sweep_unit();
		end
		swc_pkg::OP_LOAD_TIMER: begin
			divider = 12'(value);
		end
		swc_pkg::OP_LOAD_LENGTH: begin
			length_count = (value > 11'd255) ? 8'd255 : value[7:0];
		end
		swc_pkg::OP_RESTART: begin
			elapsed        = '0;
			envelope_count = envelope_cfg[3:0];
			envelope_level = 4'(ENVELOPE_TOP);
		end
		swc_pkg::OP_SWEEP_RELOAD: begin
			sweep_count = sweep_cfg[6:4];
		end
		default: begin
		end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one beat, wait for the handshake and update the predictor at the
	// accepting edge. Valid is only lowered when an idle cycle is chosen, so
	// back-to-back beats keep it high without a glitch.
	task automatic send_event(input logic [2:0] op, input logic [10:0] value,
			input bit typed, input beat_t typed_beat);
		beat_t predicted;
		bit    produced;
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= op;
		in_ch.load_value <= value;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		advance_channel(op, value, predicted, produced);
		if (produced)
			level_queue.push_back(typed ? typed_beat : predicted);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Stop offering, let every owed beat drain, then give the channel the
	// latency of one more tick so that no work is left in flight.
	task automatic wait_until_quiet();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (level_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input swc_pkg::swc_reg_t index, input logic [23:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (index)
		swc_pkg::REG_DUTY:      duty_cfg     = data[8:0];
		swc_pkg::REG_ENABLE:    enable_cfg   = data[0];
		swc_pkg::REG_HALT:      halt_cfg     = data[0];
		swc_pkg::REG_ENVELOPE:  envelope_cfg = data[5:0];
		swc_pkg::REG_SWEEP:     sweep_cfg    = data[7:0];
		swc_pkg::REG_TIME_STEP: step_cfg     = data;
		default: begin
		end
		endcase
	endtask

	task automatic program_channel(input logic [8:0] duty, input logic enable,
			input logic halt, input logic [5:0] envelope, input logic [7:0] sweep,
			input logic [23:0] step);
		write_register(swc_pkg::REG_DUTY, 24'(duty));
		write_register(swc_pkg::REG_ENABLE, 24'(enable));
		write_register(swc_pkg::REG_HALT, 24'(halt));
		write_register(swc_pkg::REG_ENVELOPE, 24'(envelope));
		write_register(swc_pkg::REG_SWEEP, 24'(sweep));
		write_register(swc_pkg::REG_TIME_STEP, step);
	endtask

	// Settings per phase. The first four pin the extremes: always-high and
	// over-range duty, channel off, constant volume and looping envelope,
	// every sweep direction with shifts of zero and seven, and time steps of
	// zero, one and the largest value. The rest are drawn at random.
	task automatic configure_phase(input int phase);
		case (phase)
		0: program_channel(9'd128, 1'b1, 1'b0, 6'h05, 8'hA9, 24'd166185);
		1: program_channel(9'd256, 1'b1, 1'b1, 6'h3F, 8'h80, 24'd1);
		2: program_channel(9'd0, 1'b0, 1'b0, 6'h00, 8'hFF, 24'hFFFFFF);
		3: program_channel(9'd511, 1'b1, 1'b0, 6'h20, 8'h88, 24'd0);
		default: program_channel(
			($urandom_range(0, 3) == 0) ? 9'($urandom_range(257, 511))
			                            : 9'($urandom_range(0, 256)),
			1'($urandom_range(0, 4) != 0),
			1'($urandom_range(0, 1)),
			6'($urandom_range(0, 63)),
			8'($urandom_range(0, 255)),
			$urandom_range(0, 1) ? 24'($urandom_range(1, 24'hFFFFFF))
			                     : 24'($urandom_range(1000, 400000)));
		endcase
	endtask

	// Random operations shaped like a running sound driver: mostly sample
	// ticks with frame events, timer and length loads in between, mostly
	// well-formed values, and a sprinkling of out-of-range loads and unused
	// codes.
	task automatic send_random_event();
		int          pick;
		int          shape;
		logic [2:0]  op;
		logic [10:0] value;
		pick  = $urandom_range(0, 99);
		shape = $urandom_range(0, 99);
		value = 11'($urandom_range(0, 2047));
		if (pick < 45) begin
			op = swc_pkg::OP_TICK;
		end else if (pick < 55) begin
			op = swc_pkg::OP_QUARTER;
		end else if (pick < 65) begin
			op = swc_pkg::OP_HALF;
		end else if (pick < 75) begin
			op = swc_pkg::OP_LOAD_TIMER;
			if (shape < 80)
				value = 11'($urandom_range(MIN_TIMER, MAX_TIMER));
			else if (shape < 90)
				value = 11'($urandom_range(0, MIN_TIMER - 1));
		end else if (pick < 83) begin
			op = swc_pkg::OP_LOAD_LENGTH;
			if (shape >= 20)
				value = 11'($urandom_range(1, 255));
		end else if (pick < 89) begin
			op = swc_pkg::OP_RESTART;
		end else if (pick < 95) begin
			op = swc_pkg::OP_SWEEP_RELOAD;
		end else begin
			op = OP_UNUSED;
		end
		send_event(op, value, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------

	// Ready is chosen at each falling edge. A long hold-off, once asked for,
	// is counted here so that the sender keeps pushing while the channel's
	// output sits full and its input backs up.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Every accepted output beat is matched against the oldest owed beat.
	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (level_queue.size() == 0) begin
				$error("output beat with no sample tick pending: level %0d timer %0d",
					out_ch.sample_level, out_ch.timer_now);
				error_count++;
			end else begin
				want = level_queue.pop_front();
				if (out_ch.sample_level !== want.level) begin
					$error("sample_level: expected %0d, got %0d", want.level,
						out_ch.sample_level);
					error_count++;
				end
				if (out_ch.timer_now !== want.timer) begin
					$error("timer_now: expected %0d, got %0d", want.timer,
						out_ch.timer_now);
					error_count++;
				end
				beats_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.operation   = '0;
		in_ch.load_value  = '0;
		out_ch.ready      = 1'b0;
		error_count       = 0;
		items_sent        = 0;
		beats_checked     = 0;
		cycle_count       = 0;
		sender_idle_pct   = 22;
		receiver_idle_pct = 45;
		hold_request      = 1'b0;
		hold_left         = 0;

		// Predictor starts from the channel's reset values.
		duty_cfg       = '0;
		enable_cfg     = 1'b0;
		halt_cfg       = 1'b0;
		envelope_cfg   = 6'd31;
		sweep_cfg      = '0;
		step_cfg       = 24'd166185;
		elapsed        = '0;
		divider        = '0;
		sweep_count    = '0;
		envelope_count = '0;
		envelope_level = 4'(ENVELOPE_TOP);
		length_count   = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: always-high duty at constant volume fifteen, so the
		// typed rows read straight off the mute rules: timer below the
		// minimum, at the minimum and at the maximum, an empty length
		// counter, and a length load that saturates.
		program_channel(9'd256, 1'b1, 1'b0, 6'h1F, 8'h00, 24'd166185);
		foreach (directed_rows[i])
			send_event(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].typed, {directed_rows[i].level, directed_rows[i].timer});

		// Random part, one register setting per phase. Idling goes from a
		// busy receiver, to a busy sender, to none at all.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_until_quiet();
			configure_phase(phase);
			if (phase < 3) begin
				sender_idle_pct   = 22;
				receiver_idle_pct = 45;
			end else if (phase < 6) begin
				sender_idle_pct   = 45;
				receiver_idle_pct = 22;
			end else begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			if (phase == 1 || phase == 6)
				hold_request = 1'b1;
			for (int n = items_sent + ITEMS_PER_PHASE; items_sent < n; )
				send_random_event();
		end

		wait_until_quiet();

		$display("Covered %0d operation beats over %0d register settings plus a directed",
			items_sent, NUM_PHASES);
		$display("sequence; %0d sample beats compared, %0d mismatches.", beats_checked,
			error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
